### src/rotary_encoder_decoder_lockout_core_macros.svh
// Assertion macros shared by the rotary encoder decoder modules.
`ifndef ROTARY_ENCODER_DECODER_LOCKOUT_CORE_MACROS_SVH
`define ROTARY_ENCODER_DECODER_LOCKOUT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RDL_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define RDL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/rdl_pkg.sv
// Types, constants and the direction classifier for the rotary encoder decoder.
package rdl_pkg;

  localparam int unsigned LockoutW = 16;
  localparam int unsigned TickW    = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_LOCKOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_POLL    = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_SETTLE  = 2'd2;

  localparam logic [LockoutW-1:0] LOCKOUT_RESET = 16'd300;
  localparam logic [TickW-1:0]    POLL_RESET    = 8'd20;
  localparam logic [TickW-1:0]    SETTLE_RESET  = 8'd15;

  localparam logic [1:0] DIR_NONE = 2'd0;
  localparam logic [1:0] DIR_CW   = 2'd1;
  localparam logic [1:0] DIR_CCW  = 2'd2;

  typedef struct packed {
    logic [LockoutW-1:0] lockout_ticks;
    logic [TickW-1:0]    poll_ticks;
    logic [TickW-1:0]    settle_ticks;
  } cfg_t;

  typedef struct packed {
    logic [1:0] step;
    logic       suppressed;
  } result_t;

  function automatic logic [1:0] classify(input logic [1:0] from_code,
                                          input logic [1:0] to_code);
    logic [1:0] dir;
    dir = DIR_NONE;
    case ({from_code, to_code})
      4'b00_10, 4'b11_01: dir = DIR_CW;
      4'b00_01, 4'b11_10: dir = DIR_CCW;
      default:            dir = DIR_NONE;
    endcase
    return dir;
  endfunction

endpackage

### src/rdl_cfg_regs.sv
// Configuration register file for the rotary encoder decoder.
module rdl_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             wr_en,
  input  logic [rdl_pkg::CfgIdxW-1:0]      wr_index,
  input  logic [rdl_pkg::CfgDataW-1:0]     wr_data,
  output rdl_pkg::cfg_t                    cfg
);
  import rdl_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ticks <= LOCKOUT_RESET;
      cfg_r.poll_ticks    <= POLL_RESET;
      cfg_r.settle_ticks  <= SETTLE_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        CFG_LOCKOUT: cfg_r.lockout_ticks <= wr_data[LockoutW-1:0];
        CFG_POLL:    cfg_r.poll_ticks    <= wr_data[TickW-1:0];
        CFG_SETTLE:  cfg_r.settle_ticks  <= wr_data[TickW-1:0];
        default:     ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

### src/rdl_tracker.sv
// Phase tracking, direction decoding and reversal lockout for each tick.
`include "rotary_encoder_decoder_lockout_core_macros.svh"

module rdl_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             pin_a,
  input  logic             pin_b,
  input  rdl_pkg::cfg_t    cfg,
  output rdl_pkg::result_t res
);
  import rdl_pkg::*;

  typedef enum logic [1:0] {
    PH_CAPTURE = 2'd0,
    PH_POLL    = 2'd1,
    PH_SETTLE  = 2'd2,
    PH_WAITEQ  = 2'd3
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [1:0]          base_r, base_nxt;
  logic [TickW-1:0]    wait_r, wait_nxt;
  logic [LockoutW-1:0] since_r, since_nxt;
  logic [1:0]          last_dir_r, last_dir_nxt;

  logic [1:0]          code;
  logic [1:0]          dir;
  logic [1:0]          opposite;
  logic [TickW-1:0]    wait_inc;
  logic [TickW-1:0]    interval;
  logic [LockoutW-1:0] since_inc;

  always_comb begin
    code      = {pin_a, pin_b};
    dir       = classify(base_r, code);
    opposite  = (dir == DIR_CW) ? DIR_CCW : DIR_CW;
    wait_inc  = wait_r + TickW'(1);
    interval  = (cfg.poll_ticks == '0) ? TickW'(1) : cfg.poll_ticks;
    since_inc = (since_r != '1) ? since_r + LockoutW'(1) : since_r;

    phase_nxt      = phase_r;
    base_nxt       = base_r;
    wait_nxt       = wait_r;
    since_nxt      = since_inc;
    last_dir_nxt   = last_dir_r;
    res.step       = DIR_NONE;
    res.suppressed = 1'b0;

    unique case (phase_r)
      PH_CAPTURE: begin
        base_nxt  = code;
        wait_nxt  = '0;
        phase_nxt = PH_POLL;
      end
      PH_POLL: begin
        wait_nxt = wait_inc;
        if (wait_inc >= interval) begin
          wait_nxt = '0;
          if (code != base_r) begin
            if (dir != DIR_NONE) begin
              if (since_inc < cfg.lockout_ticks && last_dir_r == opposite) begin
                res.suppressed = 1'b1;
              end else begin
                res.step     = dir;
                last_dir_nxt = dir;
                since_nxt    = '0;
              end
            end
            phase_nxt = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        wait_nxt = wait_inc;
        if (wait_inc >= cfg.settle_ticks) begin
          wait_nxt  = '0;
          phase_nxt = PH_WAITEQ;
        end
      end
      PH_WAITEQ: begin
        if (pin_a == pin_b) begin
          phase_nxt = PH_CAPTURE;
        end
      end
      default: phase_nxt = PH_CAPTURE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_CAPTURE;
      base_r     <= '0;
      wait_r     <= '0;
      since_r    <= '0;
      last_dir_r <= DIR_NONE;
    end else if (advance) begin
      phase_r    <= phase_nxt;
      base_r     <= base_nxt;
      wait_r     <= wait_nxt;
      since_r    <= since_nxt;
      last_dir_r <= last_dir_nxt;
    end
  end

  `RDL_ASSERT_NOW(a_step_excl_supp, res.step != DIR_NONE, !res.suppressed,
                  "A step and a suppression were reported together.")
  `RDL_ASSERT_NOW(a_result_in_poll, res.step != DIR_NONE || res.suppressed,
                  phase_r == PH_POLL, "A result was raised outside the polling phase.")
  `RDL_ASSERT_NEXT(a_step_clears_timer, advance && res.step != DIR_NONE,
                   since_r == '0 && last_dir_r == $past(res.step),
                   "An accepted step did not restart the lockout timer.")

endmodule

### src/rotary_encoder_decoder_lockout_core.sv
// Top level of the rotary encoder decoder with reversal lockout.
//
//  Channel | Direction | Ports                                   | Transfer
//  in      | request   | in_valid, in_ready, in_pin_a, in_pin_b   | one tick sample
//  out     | response  | out_valid, out_ready, out_step, out_*    | one result per tick
//  cfg     | request   | cfg_valid, cfg_ready, cfg_index, cfg_data| one register write
//
// Each request is decoded combinationally and its result is held in one output register.
// A new request is taken every cycle while the output register is empty or being drained.
// The output register is the only stage, so a result appears in the cycle after its request is taken.
// Reset is synchronous and active low; it restores the register defaults and the state.
// Configuration writes are always accepted and take effect on the next request.
`include "rotary_encoder_decoder_lockout_core_macros.svh"

module rotary_encoder_decoder_lockout_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_pin_a,
  input  logic                         in_pin_b,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_step,
  output logic                         out_suppressed,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [rdl_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [rdl_pkg::CfgDataW-1:0] cfg_data
);
  import rdl_pkg::*;

  cfg_t    cfg;
  result_t res;
  result_t out_r;
  logic    out_valid_r;
  logic    in_accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;

  rdl_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  rdl_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (in_accept),
    .pin_a   (in_pin_a),
    .pin_b   (in_pin_b),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_step       = out_r.step;
  assign out_suppressed = out_r.suppressed;

  `RDL_ASSERT_NEXT(a_accept_fills_out, in_accept, out_valid_r,
                   "An accepted request did not produce a result.")
  `RDL_ASSERT_NOW(a_step_code_legal, out_valid_r, out_step != 2'd3,
                  "The result carries an undefined step code.")
  `RDL_ASSERT_NEXT(a_result_kept, out_valid_r && !out_ready, $stable(out_r),
                   "A waiting result changed before it was taken.")

endmodule

### test/rotary_encoder_decoder_lockout_core_tb.sv
// Self-checking testbench for the rotary encoder decoder with reversal lockout.
`timescale 1ns / 100ps

module rotary_encoder_decoder_lockout_core_tb;
  import rdl_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;

  localparam logic [CfgIdxW-1:0] CFG_SPARE = 2'd3;

  localparam logic [1:0] DETENT_LOW  = 2'b00;
  localparam logic [1:0] DETENT_HIGH = 2'b11;
  localparam logic [1:0] MID_A       = 2'b10;
  localparam logic [1:0] MID_B       = 2'b01;

  typedef enum logic [1:0] {
    PH_CAPTURE,
    PH_POLL,
    PH_SETTLE,
    PH_WAITEQ
  } decode_phase_t;

  typedef struct packed {
    logic a;
    logic b;
  } tick_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_pin_a;
  logic                in_pin_b;
  logic                out_valid;
  logic                out_ready;
  logic [1:0]          out_step;
  logic                out_suppressed;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  rotary_encoder_decoder_lockout_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pin_a       (in_pin_a),
    .in_pin_b       (in_pin_b),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_step       (out_step),
    .out_suppressed (out_suppressed),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  tick_t   tick_queue[$];
  result_t predicted_results[$];

  logic [LockoutW-1:0] cur_lockout;
  logic [TickW-1:0]    cur_poll;
  logic [TickW-1:0]    cur_settle;

  decode_phase_t       dec_phase;
  logic [1:0]          base_code;
  logic [TickW-1:0]    wait_cnt;
  logic [LockoutW-1:0] since_step;
  logic [1:0]          last_dir;

  logic [1:0] cur_detent;
  int         queued_ticks;
  int         in_gap;
  int         out_stall;
  bit         in_burst;
  bit         out_burst;
  logic       in_taken;
  logic       out_taken;

  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned ticks_checked;
  int unsigned cw_count;
  int unsigned ccw_count;
  int unsigned suppressed_count;
  int unsigned reg_writes;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic result_t decode_tick(input logic a, input logic b);
    logic [1:0]       code;
    logic [1:0]       dir;
    logic [1:0]       reverse;
    logic [TickW-1:0] interval;
    result_t          res;
    code = {a, b};
    res = '0;
    interval = (cur_poll == '0) ? TickW'(1) : cur_poll;
    if (since_step != '1) since_step = since_step + 1'b1;
    case (dec_phase)
      PH_CAPTURE: begin
        base_code = code;
        wait_cnt = '0;
        dec_phase = PH_POLL;
      end
      PH_POLL: begin
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= interval) begin
          wait_cnt = '0;
          if (code != base_code) begin
            dir = DIR_NONE;
            if ((base_code == DETENT_LOW && code == MID_A) ||
                (base_code == DETENT_HIGH && code == MID_B)) begin
              dir = DIR_CW;
            end else if ((base_code == DETENT_LOW && code == MID_B) ||
                         (base_code == DETENT_HIGH && code == MID_A)) begin
              dir = DIR_CCW;
            end
            if (dir != DIR_NONE) begin
              reverse = (dir == DIR_CW) ? DIR_CCW : DIR_CW;
              if (since_step < cur_lockout && last_dir == reverse) begin
                res.suppressed = 1'b1;
              end else begin
                res.step = dir;
                last_dir = dir;
                since_step = '0;
              end
            end
            dec_phase = PH_SETTLE;
          end
        end
      end
      PH_SETTLE: begin
        wait_cnt = wait_cnt + 1'b1;
        if (wait_cnt >= cur_settle) begin
          wait_cnt = '0;
          dec_phase = PH_WAITEQ;
        end
      end
      default: begin
        if (a == b) dec_phase = PH_CAPTURE;
      end
    endcase
    return res;
  endfunction

  function automatic int draw_wait(input bit burst);
    if (burst) return 0;
    return $urandom_range(0, 15);
  endfunction

  // Requests are sampled and predicted at the rising edge; results are checked there too.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin : track
      result_t exp_res;
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        case (cfg_index)
          CFG_LOCKOUT: cur_lockout = cfg_data;
          CFG_POLL:    cur_poll    = cfg_data[TickW-1:0];
          CFG_SETTLE:  cur_settle  = cfg_data[TickW-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        exp_res = decode_tick(in_pin_a, in_pin_b);
        predicted_results.push_back(exp_res);
      end
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          $error("result with no request outstanding: step %0d suppressed %0d",
                 out_step, out_suppressed);
          fail_count++;
        end else begin
          exp_res = predicted_results.pop_front();
          ticks_checked++;
          if (exp_res.step == DIR_CW) cw_count++;
          if (exp_res.step == DIR_CCW) ccw_count++;
          if (exp_res.suppressed) suppressed_count++;
          if (out_step !== exp_res.step) begin
            $error("step: expected %0d, actual %0d", exp_res.step, out_step);
            fail_count++;
          end
          if (out_suppressed !== exp_res.suppressed) begin
            $error("suppressed: expected %0d, actual %0d", exp_res.suppressed,
                   out_suppressed);
            fail_count++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin : drive
      tick_t nxt;
      if (in_valid && !in_taken) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap = in_gap - 1;
      end else if (tick_queue.size() > 0) begin
        nxt = tick_queue.pop_front();
        in_valid <= 1'b1;
        in_pin_a <= nxt.a;
        in_pin_b <= nxt.b;
        if ($urandom_range(0, 31) == 0) in_burst = !in_burst;
        in_gap = draw_wait(in_burst);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if ($urandom_range(0, 31) == 0) out_burst = !out_burst;
        out_stall = draw_wait(out_burst);
      end
      if (out_stall == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        if (out_valid) out_stall = out_stall - 1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("rotary_encoder_decoder_lockout_core regression: fail");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(input int lockout, input int poll, input int settle);
    write_reg(CFG_LOCKOUT, CfgDataW'(lockout));
    write_reg(CFG_POLL, {8'($urandom_range(0, 255)), 8'(poll)});
    write_reg(CFG_SETTLE, {8'($urandom_range(0, 255)), 8'(settle)});
  endtask

  task automatic add_hold(input logic [1:0] code, input int count);
    tick_t t;
    t.a = code[1];
    t.b = code[0];
    repeat (count) tick_queue.push_back(t);
    queued_ticks += count;
  endtask

  // Mostly clean detent-to-detent turns of random direction and dwell, with some chatter.
  task automatic add_random_ticks(input int count, input int span);
    int        start;
    bit        cw;
    logic [1:0] mid;
    logic [1:0] dest;
    start = queued_ticks;
    while (queued_ticks - start < count) begin
      if ($urandom_range(0, 4) != 0) begin
        cw = $urandom_range(0, 1);
        if (cur_detent == DETENT_LOW) begin
          mid = cw ? MID_A : MID_B;
          dest = DETENT_HIGH;
        end else begin
          mid = cw ? MID_B : MID_A;
          dest = DETENT_LOW;
        end
        add_hold(mid, $urandom_range(1, span));
        add_hold(dest, $urandom_range(1, span));
        cur_detent = dest;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          add_hold(2'($urandom_range(0, 3)), $urandom_range(1, span / 4 + 1));
        end
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (tick_queue.size() != 0 || in_valid || predicted_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int lockout, input int poll, input int settle,
                           input int count);
    int eff_poll;
    eff_poll = (poll == 0) ? 1 : poll;
    write_settings(lockout, poll, settle);
    add_random_ticks(count, eff_poll + settle + 4);
    wait_idle();
  endtask

  initial begin : stimulus
    logic [1:0] directed [25];
    directed = '{DETENT_LOW, MID_A, MID_A, DETENT_HIGH, DETENT_HIGH, MID_A, MID_A, MID_B,
                 DETENT_LOW, DETENT_LOW, MID_B, MID_B, DETENT_LOW, DETENT_HIGH, DETENT_HIGH,
                 DETENT_LOW, DETENT_HIGH, MID_B, MID_B, DETENT_LOW, DETENT_LOW, DETENT_HIGH,
                 MID_A, MID_A, DETENT_LOW};
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_pin_a  = 1'b0;
    in_pin_b  = 1'b0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_gap = 0;
    out_stall = 0;
    in_burst = 1'b0;
    out_burst = 1'b0;
    queued_ticks = 0;
    cur_detent = DETENT_LOW;
    cycle_count = 0;
    fail_count = 0;
    ticks_checked = 0;
    cw_count = 0;
    ccw_count = 0;
    suppressed_count = 0;
    reg_writes = 0;
    cur_lockout = LOCKOUT_RESET;
    cur_poll    = POLL_RESET;
    cur_settle  = SETTLE_RESET;
    dec_phase   = PH_CAPTURE;
    base_code   = '0;
    wait_cnt    = '0;
    since_step  = '0;
    last_dir    = DIR_NONE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // A few ticks at the reset defaults before any register is touched.
    add_hold(DETENT_LOW, 4);
    wait_idle();

    // Fast polling and zero settling so that short sequences reach every phase.
    write_settings(5, 1, 0);
    foreach (directed[i]) add_hold(directed[i], 1);
    wait_idle();

    run_phase(LOCKOUT_RESET, POLL_RESET, SETTLE_RESET, 200);
    run_phase(0, 0, 0, 200);
    run_phase(40, 3, 2, 250);
    run_phase(65535, 2, 255, 200);
    run_phase(12, 255, 1, 300);
    run_phase($urandom_range(0, 80), $urandom_range(1, 8), $urandom_range(0, 8), 100);
    write_reg(CFG_SPARE, CfgDataW'($urandom_range(0, 65535)));
    run_phase($urandom_range(0, 80), $urandom_range(1, 8), $urandom_range(0, 8), 100);
    run_phase($urandom_range(0, 80), $urandom_range(1, 8), $urandom_range(0, 8), 100);

    repeat (10) @(negedge clk);
    $display("Checked %0d tick results over %0d register writes.", ticks_checked, reg_writes);
    $display("Predicted %0d clockwise, %0d counter-clockwise and %0d suppressed steps.",
             cw_count, ccw_count, suppressed_count);
    if (fail_count == 0 && predicted_results.size() == 0) begin
      $display("rotary_encoder_decoder_lockout_core regression: pass");
    end else begin
      $display("rotary_encoder_decoder_lockout_core regression: fail");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/rdl_pkg.sv
src/rdl_cfg_regs.sv
src/rdl_tracker.sv
src/rotary_encoder_decoder_lockout_core.sv
test/rotary_encoder_decoder_lockout_core_tb.sv
